>>> rtl/pfsa_pkg.sv
// shared types and constants of the page frame stack allocator
`default_nettype none

package pfsa_pkg;

	localparam int IN_ADDR_W  = 48;
	localparam int FREE_W     = 13;
	localparam int PAGE_SHIFT = 12;
	localparam int FRAME_BYTES = 4096;
	localparam int LOW_LIMIT_ADDR = 'h100000;
	localparam int LOW_LIMIT_PFN  = LOW_LIMIT_ADDR / FRAME_BYTES;

	localparam logic [1:0] CMD_CLEAR  = 2'd0;
	localparam logic [1:0] CMD_REGION = 2'd1;
	localparam logic [1:0] CMD_ALLOC  = 2'd2;
	localparam logic [1:0] CMD_FREE   = 2'd3;

	typedef enum logic [2:0] {
		OP_CLEAR,
		OP_REGION,
		OP_ALLOC,
		OP_FREE,
		OP_NOP
	} op_kind_t;

	localparam int KIND_W = $bits(op_kind_t);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_REGION,
		ST_POP
	} back_state_t;

endpackage

`default_nettype wire

>>> rtl/pfsa_fifo.sv
// two-entry operation queue between the front and the back part
`default_nettype none

module pfsa_fifo #(
	parameter int DATA_W = 8
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              wr_valid,
	output      logic              wr_stall,
	input  wire logic [DATA_W-1:0] wr_data,
	output      logic              rd_valid,
	input  wire logic              rd_take,
	output      logic [DATA_W-1:0] rd_data
);

	logic [DATA_W-1:0] mem_q [2];
	logic              wr_ptr_q;
	logic              rd_ptr_q;
	logic [1:0]        fill_q;
	logic              do_wr;
	logic              do_rd;

	assign wr_stall = (fill_q == 2'd2);
	assign rd_valid = (fill_q != 2'd0);
	assign rd_data  = mem_q[rd_ptr_q];
	assign do_wr    = wr_valid && !wr_stall;
	assign do_rd    = rd_take && rd_valid;

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			fill_q   <= 2'd0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_rd) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({do_wr, do_rd})
				2'b10:   fill_q <= fill_q + 2'd1;
				2'b01:   fill_q <= fill_q - 2'd1;
				default: fill_q <= fill_q;
			endcase
		end
	end

	a_fill_range: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q != 2'd3)
		else $error("queue fill out of range");
	a_ptr_match: assert property (@(posedge clk) disable iff (!arst_n)
		(fill_q == 2'd0 || fill_q == 2'd2) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill");
	a_ptr_split: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q == 2'd1 |-> wr_ptr_q != rd_ptr_q)
		else $error("queue pointers disagree with single entry");

endmodule

`default_nettype wire

>>> rtl/pfsa_front.sv
// command classifier: page rounding and clipping of regions, frame number of frees
`default_nettype none

module pfsa_front #(
	parameter int PHYS_ADDR_BITS = 48
) (
	input  wire logic [1:0]                     cmd,
	input  wire logic [pfsa_pkg::IN_ADDR_W-1:0] region_base,
	input  wire logic [pfsa_pkg::IN_ADDR_W-1:0] region_length,
	input  wire logic                           region_usable,
	input  wire logic [pfsa_pkg::IN_ADDR_W-1:0] page_addr_in,
	output      logic [pfsa_pkg::KIND_W+2*(PHYS_ADDR_BITS-pfsa_pkg::PAGE_SHIFT+1)-1:0] op
);

	localparam int PFN_W  = PHYS_ADDR_BITS - pfsa_pkg::PAGE_SHIFT;
	localparam int OPV_W  = PFN_W + 1;
	localparam int SUM_W  = pfsa_pkg::IN_ADDR_W + 1;
	localparam int SPAN_W = (PFN_W + 1 > SUM_W - pfsa_pkg::PAGE_SHIFT + 1)
		? PFN_W + 1 : SUM_W - pfsa_pkg::PAGE_SHIFT + 1;

	logic [SUM_W-1:0]   first_sum;
	logic [SUM_W-1:0]   end_sum;
	logic [SPAN_W-1:0]  first_pfn;
	logic [SPAN_W-1:0]  end_pfn;
	logic [SPAN_W-1:0]  pfn_lim;
	pfsa_pkg::op_kind_t kind;
	logic [OPV_W-1:0]   val_a;
	logic [OPV_W-1:0]   val_b;

	always_comb begin
		first_sum = {1'b0, region_base} + SUM_W'(pfsa_pkg::FRAME_BYTES - 1);
		end_sum   = {1'b0, region_base} + {1'b0, region_length};
		first_pfn = SPAN_W'(first_sum[SUM_W-1:pfsa_pkg::PAGE_SHIFT]);
		end_pfn   = SPAN_W'(end_sum[SUM_W-1:pfsa_pkg::PAGE_SHIFT]);
		pfn_lim   = SPAN_W'(1) << PFN_W;
		// clip to the address space, skip everything below 1 MiB
		if (end_pfn > pfn_lim) begin
			end_pfn = pfn_lim;
		end
		if (first_pfn < SPAN_W'(pfsa_pkg::LOW_LIMIT_PFN)) begin
			first_pfn = SPAN_W'(pfsa_pkg::LOW_LIMIT_PFN);
		end
		val_a = '0;
		val_b = '0;
		case (cmd)
			pfsa_pkg::CMD_CLEAR: begin
				kind = pfsa_pkg::OP_CLEAR;
			end
			pfsa_pkg::CMD_REGION: begin
				if (region_usable && end_pfn > first_pfn) begin
					kind  = pfsa_pkg::OP_REGION;
					val_a = OPV_W'(first_pfn);
					val_b = OPV_W'(end_pfn);
				end else begin
					kind = pfsa_pkg::OP_NOP;
				end
			end
			pfsa_pkg::CMD_ALLOC: begin
				kind = pfsa_pkg::OP_ALLOC;
			end
			default: begin
				kind  = pfsa_pkg::OP_FREE;
				val_a = OPV_W'(PFN_W'(page_addr_in >> pfsa_pkg::PAGE_SHIFT));
			end
		endcase
		op = {kind, val_a, val_b};
	end

endmodule

`default_nettype wire

>>> rtl/pfsa_back.sv
// executor: frame stack memory, stack count, region sweep and result register
`default_nettype none

module pfsa_back #(
	parameter int PHYS_ADDR_BITS = 48,
	parameter int STACK_DEPTH    = 4096
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic q_valid,
	output      logic q_take,
	input  wire logic [pfsa_pkg::KIND_W+2*(PHYS_ADDR_BITS-pfsa_pkg::PAGE_SHIFT+1)-1:0] q_data,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic [pfsa_pkg::IN_ADDR_W-1:0] page_addr_out,
	output      logic                           ok,
	output      logic                           overflow,
	output      logic [pfsa_pkg::FREE_W-1:0]    free_count
);

	localparam int PFN_W = PHYS_ADDR_BITS - pfsa_pkg::PAGE_SHIFT;
	localparam int OPV_W = PFN_W + 1;
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int IDX_W = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam logic [CNT_W-1:0] FULL = CNT_W'(STACK_DEPTH);

	logic [PFN_W-1:0] frame_mem [STACK_DEPTH];
	logic [PFN_W-1:0] rd_data_q;

	pfsa_pkg::back_state_t state_q, state_d;
	logic [CNT_W-1:0] count_q, count_d;
	logic [OPV_W-1:0] cur_q, cur_d;
	logic [OPV_W-1:0] end_q, end_d;

	pfsa_pkg::op_kind_t kind;
	logic [OPV_W-1:0]   val_a;
	logic [OPV_W-1:0]   val_b;

	logic             res_free;
	logic             emit;
	logic             emit_ok;
	logic             emit_ovf;
	logic             emit_from_mem;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	logic [PFN_W-1:0] mem_wdata;
	logic             mem_re;
	logic [IDX_W-1:0] mem_raddr;
	logic [CNT_W-1:0] count_dec;

	logic                           out_valid_q;
	logic [pfsa_pkg::IN_ADDR_W-1:0] page_addr_q;
	logic                           ok_q;
	logic                           ovf_q;
	logic [pfsa_pkg::FREE_W-1:0]    free_q;

	assign kind  = pfsa_pkg::op_kind_t'(q_data[pfsa_pkg::KIND_W+2*OPV_W-1:2*OPV_W]);
	assign val_a = q_data[2*OPV_W-1:OPV_W];
	assign val_b = q_data[OPV_W-1:0];
	assign res_free  = !out_valid_q || !out_stall;
	assign count_dec = count_q - CNT_W'(1);

	always_comb begin
		state_d       = state_q;
		count_d       = count_q;
		cur_d         = cur_q;
		end_d         = end_q;
		q_take        = 1'b0;
		emit          = 1'b0;
		emit_ok       = 1'b1;
		emit_ovf      = 1'b0;
		emit_from_mem = 1'b0;
		mem_we        = 1'b0;
		mem_waddr     = count_q[IDX_W-1:0];
		mem_wdata     = val_a[PFN_W-1:0];
		mem_re        = 1'b0;
		mem_raddr     = count_dec[IDX_W-1:0];
		case (state_q)
			pfsa_pkg::ST_IDLE: begin
				if (q_valid && res_free) begin
					q_take = 1'b1;
					case (kind)
						pfsa_pkg::OP_CLEAR: begin
							count_d = '0;
							emit    = 1'b1;
						end
						pfsa_pkg::OP_REGION: begin
							cur_d   = val_a;
							end_d   = val_b;
							state_d = pfsa_pkg::ST_REGION;
						end
						pfsa_pkg::OP_ALLOC: begin
							if (count_q == '0) begin
								emit    = 1'b1;
								emit_ok = 1'b0;
							end else begin
								count_d = count_dec;
								mem_re  = 1'b1;
								state_d = pfsa_pkg::ST_POP;
							end
						end
						pfsa_pkg::OP_FREE: begin
							emit = 1'b1;
							if (count_q == FULL) begin
								emit_ok  = 1'b0;
								emit_ovf = 1'b1;
							end else begin
								mem_we  = 1'b1;
								count_d = count_q + CNT_W'(1);
							end
						end
						default: begin
							emit = 1'b1;
						end
					endcase
				end
			end
			pfsa_pkg::ST_REGION: begin
				// one page per cycle, ascending, until done or the stack is full
				if (cur_q == end_q) begin
					if (res_free) begin
						emit    = 1'b1;
						state_d = pfsa_pkg::ST_IDLE;
					end
				end else if (count_q == FULL) begin
					if (res_free) begin
						emit     = 1'b1;
						emit_ok  = 1'b0;
						emit_ovf = 1'b1;
						state_d  = pfsa_pkg::ST_IDLE;
					end
				end else begin
					mem_we    = 1'b1;
					mem_wdata = cur_q[PFN_W-1:0];
					count_d   = count_q + CNT_W'(1);
					cur_d     = cur_q + OPV_W'(1);
				end
			end
			pfsa_pkg::ST_POP: begin
				if (res_free) begin
					emit          = 1'b1;
					emit_from_mem = 1'b1;
					state_d       = pfsa_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = pfsa_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			frame_mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rd_data_q <= frame_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk) begin
		cur_q <= cur_d;
		end_q <= end_d;
		if (emit) begin
			page_addr_q <= emit_from_mem
				? pfsa_pkg::IN_ADDR_W'({rd_data_q, {pfsa_pkg::PAGE_SHIFT{1'b0}}}) : '0;
			ok_q   <= emit_ok;
			ovf_q  <= emit_ovf;
			free_q <= pfsa_pkg::FREE_W'(count_d);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= pfsa_pkg::ST_IDLE;
			count_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign page_addr_out = page_addr_q;
	assign ok            = ok_q;
	assign overflow      = ovf_q;
	assign free_count    = free_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL)
		else $error("stack count beyond depth");
	a_write_room: assert property (@(posedge clk) disable iff (!arst_n)
		mem_we |-> count_q < FULL)
		else $error("frame write with full stack");
	a_sweep_order: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pfsa_pkg::ST_REGION |-> cur_q <= end_q)
		else $error("region sweep ran past its end");
	a_no_emit_overrun: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |-> !emit)
		else $error("result overwritten while stalled");

endmodule

`default_nettype wire

>>> rtl/page_frame_stack_allocator.sv
// top level of the page frame stack allocator
//
//  channel  direction  handshake            payload
//  in       sink       in_valid/in_stall    cmd, region_base, region_length,
//                                           region_usable, page_addr_in
//  out      source     out_valid/out_stall  page_addr_out, ok, overflow, free_count
//
// the front classifies one transaction per cycle into a two-entry queue, unless the queue is full
// clear, free and empty or unusable region adds post their result as they are taken
// allocate takes the top entry, then posts it from the registered frame memory read
// a region add is taken, pushes its pages in ascending order, then posts its result
// reset clears the stack count and all control state, frame memory is not cleared
// out_stall holds the result register and stops the back part when it has a result to post, the queue then stalls in
`default_nettype none

module page_frame_stack_allocator #(
	parameter int STACK_DEPTH    = 4096,
	parameter int PHYS_ADDR_BITS = 48
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	output      logic                           in_stall,
	input  wire logic [1:0]                     cmd,
	input  wire logic [pfsa_pkg::IN_ADDR_W-1:0] region_base,
	input  wire logic [pfsa_pkg::IN_ADDR_W-1:0] region_length,
	input  wire logic                           region_usable,
	input  wire logic [pfsa_pkg::IN_ADDR_W-1:0] page_addr_in,
	output      logic                           out_valid,
	input  wire logic                           out_stall,
	output      logic [pfsa_pkg::IN_ADDR_W-1:0] page_addr_out,
	output      logic                           ok,
	output      logic                           overflow,
	output      logic [pfsa_pkg::FREE_W-1:0]    free_count
);

	localparam int OPV_W = PHYS_ADDR_BITS - pfsa_pkg::PAGE_SHIFT + 1;
	localparam int OP_W  = pfsa_pkg::KIND_W + 2 * OPV_W;

	logic [OP_W-1:0] front_op;
	logic [OP_W-1:0] queue_op;
	logic            queue_valid;
	logic            queue_take;

	pfsa_front #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS)
	) u_front (
		.cmd           (cmd),
		.region_base   (region_base),
		.region_length (region_length),
		.region_usable (region_usable),
		.page_addr_in  (page_addr_in),
		.op            (front_op)
	);

	pfsa_fifo #(
		.DATA_W(OP_W)
	) u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_valid (in_valid),
		.wr_stall (in_stall),
		.wr_data  (front_op),
		.rd_valid (queue_valid),
		.rd_take  (queue_take),
		.rd_data  (queue_op)
	);

	pfsa_back #(
		.PHYS_ADDR_BITS(PHYS_ADDR_BITS),
		.STACK_DEPTH   (STACK_DEPTH)
	) u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.q_valid       (queue_valid),
		.q_take        (queue_take),
		.q_data        (queue_op),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.page_addr_out (page_addr_out),
		.ok            (ok),
		.overflow      (overflow),
		.free_count    (free_count)
	);

	a_take_needs_entry: assert property (@(posedge clk) disable iff (!arst_n)
		queue_take |-> queue_valid)
		else $error("queue taken while empty");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> out_valid && $stable(free_count))
		else $error("stalled result changed");
	a_ok_ovf: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(ok && overflow))
		else $error("result both ok and overflowed");

endmodule

`default_nettype wire

>>> tb/testbench.sv
// self-checking testbench for the page frame stack allocator
module testbench;

	localparam int STACK_DEPTH = 4096;
	localparam int IN_ADDR_W   = pfsa_pkg::IN_ADDR_W;
	localparam int FREE_W      = pfsa_pkg::FREE_W;
	localparam int PAGE_SHIFT  = pfsa_pkg::PAGE_SHIFT;
	localparam int PFN_W       = IN_ADDR_W - PAGE_SHIFT;
	localparam int PHASE_ITEMS = 170;

	typedef struct {
		logic [1:0]           cmd;
		bit [IN_ADDR_W-1:0]   base;
		bit [IN_ADDR_W-1:0]   len;
		bit                   usable;
		bit [IN_ADDR_W-1:0]   paddr;
	} page_cmd_t;

	typedef struct {
		bit [IN_ADDR_W-1:0] addr;
		bit                 ok;
		bit                 ovf;
		bit [FREE_W-1:0]    count;
	} page_result_t;

	// free page stack as the block should hold it, and the results still owed
	class page_stack_tracker;
		bit [PFN_W-1:0] frames [STACK_DEPTH];
		int unsigned    depth_used;
		page_result_t   expected_q[$];
		int             errors;
		int             printed;

		function bit push_frame(bit [PFN_W-1:0] pfn);
			if (depth_used >= STACK_DEPTH) return 1'b0;
			frames[depth_used] = pfn;
			depth_used++;
			return 1'b1;
		endfunction

		function void note_command(page_cmd_t c);
			page_result_t r;
			bit [63:0]    first_pfn;
			bit [63:0]    end_pfn;
			bit [63:0]    n;
			bit [63:0]    room;
			bit [63:0]    take;
			r.addr = '0;
			r.ok   = 1'b1;
			r.ovf  = 1'b0;
			case (c.cmd)
			pfsa_pkg::CMD_CLEAR: begin
				depth_used = 0;
			end
			pfsa_pkg::CMD_REGION: begin
				if (c.usable) begin
					first_pfn = (64'(c.base) + 64'(pfsa_pkg::FRAME_BYTES - 1)) >> PAGE_SHIFT;
					end_pfn   = (64'(c.base) + 64'(c.len)) >> PAGE_SHIFT;
					// clip at the top of the physical address space
					if (end_pfn > (64'd1 << PFN_W)) end_pfn = 64'd1 << PFN_W;
					if (first_pfn < 64'(pfsa_pkg::LOW_LIMIT_PFN))
						first_pfn = 64'(pfsa_pkg::LOW_LIMIT_PFN);
					if (end_pfn > first_pfn) begin
						n    = end_pfn - first_pfn;
						room = 64'(STACK_DEPTH) - 64'(depth_used);
						take = (n < room) ? n : room;
						for (bit [63:0] k = 0; k < take; k++) begin
							void'(push_frame(PFN_W'(first_pfn + k)));
						end
						if (n > take) begin
							r.ok  = 1'b0;
							r.ovf = 1'b1;
						end
					end
				end
			end
			pfsa_pkg::CMD_ALLOC: begin
				if (depth_used == 0) begin
					r.ok = 1'b0;
				end else begin
					depth_used--;
					r.addr = {frames[depth_used], {PAGE_SHIFT{1'b0}}};
				end
			end
			default: begin
				if (!push_frame(c.paddr[IN_ADDR_W-1:PAGE_SHIFT])) begin
					r.ok  = 1'b0;
					r.ovf = 1'b1;
				end
			end
			endcase
			r.count = FREE_W'(depth_used);
			expected_q.push_back(r);
		endfunction

		task report(string msg);
			errors++;
			if (printed < 100) begin
				$display("mismatch: %s", msg);
				printed++;
			end
		endtask

		task check_result(logic [IN_ADDR_W-1:0] addr, logic ok_bit, logic ovf_bit,
				logic [FREE_W-1:0] count);
			page_result_t e;
			if (expected_q.size() == 0) begin
				report($sformatf("unexpected transaction, addr %h count %0d", addr, count));
				return;
			end
			e = expected_q.pop_front();
			if (addr !== e.addr)
				report($sformatf("page_addr_out %h, expected %h", addr, e.addr));
			if (ok_bit !== e.ok)
				report($sformatf("ok %b, expected %b", ok_bit, e.ok));
			if (ovf_bit !== e.ovf)
				report($sformatf("overflow %b, expected %b", ovf_bit, e.ovf));
			if (count !== e.count)
				report($sformatf("free_count %0d, expected %0d", count, e.count));
		endtask
	endclass

	logic                 clk           = 1'b0;
	logic                 arst_n        = 1'b0;
	logic                 in_valid      = 1'b0;
	logic                 in_stall;
	logic [1:0]           cmd           = pfsa_pkg::CMD_CLEAR;
	logic [IN_ADDR_W-1:0] region_base   = '0;
	logic [IN_ADDR_W-1:0] region_length = '0;
	logic                 region_usable = 1'b0;
	logic [IN_ADDR_W-1:0] page_addr_in  = '0;
	logic                 out_valid;
	logic                 out_stall     = 1'b0;
	logic [IN_ADDR_W-1:0] page_addr_out;
	logic                 ok;
	logic                 overflow;
	logic [FREE_W-1:0]    free_count;

	int unsigned sender_idle_pct = 0;
	int unsigned stall_pct       = 0;

	page_stack_tracker tracker = new;

	page_frame_stack_allocator uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.cmd           (cmd),
		.region_base   (region_base),
		.region_length (region_length),
		.region_usable (region_usable),
		.page_addr_in  (page_addr_in),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.page_addr_out (page_addr_out),
		.ok            (ok),
		.overflow      (overflow),
		.free_count    (free_count)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < stall_pct);
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall)
			tracker.check_result(page_addr_out, ok, overflow, free_count);
	end

	function automatic bit [IN_ADDR_W-1:0] rand48();
		bit [63:0] v;
		v = {$urandom, $urandom};
		return v[IN_ADDR_W-1:0];
	endfunction

	task automatic send_command(page_cmd_t c);
		while ($urandom_range(99) < sender_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		cmd           <= c.cmd;
		region_base   <= c.base;
		region_length <= c.len;
		region_usable <= c.usable;
		page_addr_in  <= c.paddr;
		do @(posedge clk); while (in_stall);
		tracker.note_command(c);
	endtask

	task automatic issue(logic [1:0] op, bit [IN_ADDR_W-1:0] base, bit [IN_ADDR_W-1:0] len,
			bit usable, bit [IN_ADDR_W-1:0] paddr);
		page_cmd_t c;
		c.cmd    = op;
		c.base   = base;
		c.len    = len;
		c.usable = usable;
		c.paddr  = paddr;
		send_command(c);
	endtask

	// hold the sender off until every owed result has come back
	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_q.size() != 0);
	endtask

	function automatic page_cmd_t random_command();
		page_cmd_t   c;
		int unsigned pick;
		pick     = $urandom_range(99);
		c.base   = rand48();
		c.len    = rand48();
		c.usable = 1'($urandom_range(1));
		c.paddr  = rand48();
		if (pick < 3) begin
			c.cmd = pfsa_pkg::CMD_CLEAR;
		end else if (pick < 25) begin
			c.cmd    = pfsa_pkg::CMD_REGION;
			c.usable = ($urandom_range(9) != 0);
			if ($urandom_range(1))
				c.base = 48'h10_0000 + (IN_ADDR_W'($urandom_range(4095)) << PAGE_SHIFT)
					+ IN_ADDR_W'($urandom_range(pfsa_pkg::FRAME_BYTES - 1));
			// a few huge regions, the rest a handful of pages
			if ($urandom_range(99) >= 4)
				c.len = IN_ADDR_W'($urandom_range(40000));
		end else if (pick < 62) begin
			c.cmd = pfsa_pkg::CMD_ALLOC;
		end else begin
			c.cmd = pfsa_pkg::CMD_FREE;
		end
		return c;
	endfunction

	initial begin
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_CLEAR, '1, '1, 1'b1, '1);
		issue(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, '1);
		issue(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, 48'h0000_0000_0FFF);
		issue(pfsa_pkg::CMD_ALLOC, '1, '1, 1'b1, '1);
		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		// unusable, empty, sub-page and below 1 MiB regions push nothing
		issue(pfsa_pkg::CMD_REGION, 48'h10_0000, 48'h1_0000, 1'b0, '0);
		issue(pfsa_pkg::CMD_REGION, 48'h10_0000, '0, 1'b1, '0);
		issue(pfsa_pkg::CMD_REGION, 48'h10_0001, 48'h1000, 1'b1, '0);
		issue(pfsa_pkg::CMD_REGION, '0, 48'h8_0000, 1'b1, '0);
		// region straddling 1 MiB, then one running past the address space
		issue(pfsa_pkg::CMD_REGION, 48'h0F_E000, 48'h5800, 1'b1, '0);
		issue(pfsa_pkg::CMD_REGION, 48'hFFFF_FFFF_D800, 48'h8000, 1'b1, '0);
		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_CLEAR, '0, '0, 1'b0, '0);
		// overfill the stack, then push onto it while full
		issue(pfsa_pkg::CMD_REGION, 48'h10_0000, 48'h100_3000, 1'b1, '0);
		issue(pfsa_pkg::CMD_FREE, '0, '0, 1'b0, 48'h1234_5678_9ABC);
		issue(pfsa_pkg::CMD_REGION, 48'h20_0000, 48'h2000, 1'b1, '0);
		issue(pfsa_pkg::CMD_REGION, 48'h20_0000, 48'h2000, 1'b0, '0);
		issue(pfsa_pkg::CMD_ALLOC, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_CLEAR, '0, '0, 1'b0, '0);
		issue(pfsa_pkg::CMD_REGION, '1, '1, 1'b1, '0);
		issue(pfsa_pkg::CMD_REGION, '0, '1, 1'b1, '0);
		issue(pfsa_pkg::CMD_CLEAR, '0, '0, 1'b0, '0);

		for (int phase = 0; phase < 4; phase++) begin
			drain_results();
			case (phase)
			0: begin
				sender_idle_pct = 0;
				stall_pct       = 0;
			end
			1: begin
				sender_idle_pct = 63;
				stall_pct       = 0;
			end
			2: begin
				sender_idle_pct = 0;
				stall_pct       = 63;
			end
			default: begin
				sender_idle_pct = 12;
				stall_pct       = 12;
			end
			endcase
			for (int i = 0; i < PHASE_ITEMS; i++)
				send_command(random_command());
		end

		drain_results();
		repeat (20) @(posedge clk);
		if (tracker.expected_q.size() != 0)
			tracker.report($sformatf("%0d results never arrived", tracker.expected_q.size()));
		if (tracker.errors == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

	initial begin
		#200_000_000;
		$display("FAIL");
		$finish;
	end

endmodule
